// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/ttb_pkg.sv =====
package ttb_pkg;

  localparam int LIMIT_W = 20;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_START_HOURS   = 2'd0;
  localparam logic [1:0] REG_START_MINUTES = 2'd1;
  localparam logic [1:0] REG_START_SECONDS = 2'd2;

  // Bit positions in the pending flag vector and in ack_mask
  localparam int FLAG_100MS  = 0;
  localparam int FLAG_10MS   = 1;
  localparam int FLAG_SCR_UP = 2;
  localparam int FLAG_SCR_LO = 3;

  localparam logic [3:0] PRESCALE_DIV   = 4'd10;
  localparam logic [3:0] BLINK_TOP      = 4'd10;
  localparam logic [3:0] BLINK_ON_BELOW = 4'd8;
  localparam logic [1:0] SCROLL_TOP     = 2'd2;
  localparam logic [6:0] MINUTE_LEN     = 7'd60;
  localparam logic [6:0] HOUR_LEN       = 7'd60;
  localparam logic [5:0] HOURS_TOP      = 6'd24;
  localparam logic [4:0] HOURS_WRAP     = 5'd1;

  typedef struct packed {
    logic        mode;
    logic [3:0]  ack_mask;
    logic        clear_interval;
    logic        clear_phase;
    logic [15:0] limit_seconds;
  } in_word_t;

  typedef struct packed {
    logic       flag_100ms;
    logic       flag_10ms;
    logic       scroll_upper;
    logic       scroll_lower;
    logic       interval_passed;
    logic       phase_passed;
    logic       blink_on;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [3:0] tenths;
  } out_word_t;

  typedef struct packed {
    logic [1:0] index;
    logic [5:0] value;
  } cfg_word_t;

  // Item held in the input stage, limit already scaled to tenths
  typedef struct packed {
    logic               mode;
    logic [3:0]         ack_mask;
    logic               clear_interval;
    logic               clear_phase;
    logic [LIMIT_W-1:0] limit_tenths;
  } item_t;

  typedef struct packed {
    logic      en;
    cfg_word_t word;
  } cfg_wr_t;

endpackage

// ===== hw/rtl/ttb_if.sv =====
interface ttb_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ttb_in_stage.sv =====
module ttb_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  ttb_if.sink            in_ch,
  input  logic           advance,
  output logic           item_valid,
  output ttb_pkg::item_t item
);

  logic           valid_r;
  ttb_pkg::item_t item_r;
  logic [ttb_pkg::LIMIT_W-1:0] limit_ext;

  assign in_ch.ready = !valid_r || advance;
  assign item_valid  = valid_r;
  assign item        = item_r;

  // limit * 10 as (limit << 3) + (limit << 1)
  assign limit_ext = {{(ttb_pkg::LIMIT_W-16){1'b0}}, in_ch.data.limit_seconds};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.mode           <= in_ch.data.mode;
      item_r.ack_mask       <= in_ch.data.ack_mask;
      item_r.clear_interval <= in_ch.data.clear_interval;
      item_r.clear_phase    <= in_ch.data.clear_phase;
      item_r.limit_tenths   <= (limit_ext << 3) + (limit_ext << 1);
    end
  end

endmodule

// ===== hw/rtl/ttb_core.sv =====
module ttb_core #(
  parameter int TENTHS_PER_SECOND = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ttb_pkg::cfg_wr_t   cfg,
  input  logic               advance,
  input  ttb_pkg::item_t     item,
  output ttb_pkg::out_word_t result
);

  logic [3:0]  prescale_r, prescale_nxt;
  logic [15:0] interval_r, interval_nxt;
  logic [15:0] phase_r, phase_nxt;
  logic [3:0]  blink_r, blink_nxt;
  logic [1:0]  scroll_r, scroll_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [3:0]  tenths_r, tenths_nxt;
  logic [5:0]  seconds_r, seconds_nxt;
  logic [5:0]  minutes_r, minutes_nxt;
  logic [4:0]  hours_r, hours_nxt;

  logic [3:0] prescale_inc, blink_inc, tenths_inc;
  logic [1:0] scroll_inc;
  logic [6:0] seconds_inc, minutes_inc;
  logic [5:0] hours_inc;

  assign prescale_inc = prescale_r + 4'd1;
  assign blink_inc    = blink_r + 4'd1;
  assign tenths_inc   = tenths_r + 4'd1;
  assign scroll_inc   = scroll_r + 2'd1;
  assign seconds_inc  = {1'b0, seconds_r} + 7'd1;
  assign minutes_inc  = {1'b0, minutes_r} + 7'd1;
  assign hours_inc    = {1'b0, hours_r} + 6'd1;

  always_comb begin
    prescale_nxt = prescale_r;
    interval_nxt = interval_r;
    phase_nxt    = phase_r;
    blink_nxt    = blink_r;
    scroll_nxt   = scroll_r;
    flags_nxt    = flags_r;
    tenths_nxt   = tenths_r;
    seconds_nxt  = seconds_r;
    minutes_nxt  = minutes_r;
    hours_nxt    = hours_r;
    if (cfg.en) begin
      // start time loads straight into the clock
      case (cfg.word.index)
        ttb_pkg::REG_START_HOURS:   hours_nxt   = cfg.word.value[4:0];
        ttb_pkg::REG_START_MINUTES: minutes_nxt = cfg.word.value;
        ttb_pkg::REG_START_SECONDS: seconds_nxt = cfg.word.value;
        default: ;
      endcase
    end else if (advance) begin
      if (!item.mode) begin
        flags_nxt[ttb_pkg::FLAG_10MS] = 1'b1;
        if (prescale_inc >= ttb_pkg::PRESCALE_DIV) begin
          prescale_nxt = 4'd0;
          flags_nxt[ttb_pkg::FLAG_100MS] = 1'b1;
          interval_nxt = interval_r + 16'd1;
          phase_nxt    = phase_r + 16'd1;
          blink_nxt    = (blink_inc > ttb_pkg::BLINK_TOP) ? 4'd0 : blink_inc;
          // ripple the time of day
          if (tenths_inc < 4'(TENTHS_PER_SECOND)) begin
            tenths_nxt = tenths_inc;
          end else begin
            tenths_nxt = 4'd0;
            if (seconds_inc < ttb_pkg::MINUTE_LEN) begin
              seconds_nxt = seconds_inc[5:0];
            end else begin
              seconds_nxt = 6'd0;
              if (minutes_inc < ttb_pkg::HOUR_LEN) begin
                minutes_nxt = minutes_inc[5:0];
              end else begin
                minutes_nxt = 6'd0;
                hours_nxt = (hours_inc > ttb_pkg::HOURS_TOP) ? ttb_pkg::HOURS_WRAP
                                                             : hours_inc[4:0];
              end
            end
          end
        end else begin
          prescale_nxt = prescale_inc;
          if (scroll_inc == 2'd1) begin
            flags_nxt[ttb_pkg::FLAG_SCR_UP] = 1'b1;
          end else if (scroll_inc == 2'd2) begin
            flags_nxt[ttb_pkg::FLAG_SCR_LO] = 1'b1;
          end
          scroll_nxt = (scroll_inc > ttb_pkg::SCROLL_TOP) ? 2'd0 : scroll_inc;
        end
      end else begin
        flags_nxt = flags_r & ~item.ack_mask;
      end
      if (item.clear_interval) begin
        interval_nxt = 16'd0;
      end
      if (item.clear_phase) begin
        phase_nxt = 16'd0;
      end
    end
  end

  always_comb begin
    result.flag_100ms      = flags_nxt[ttb_pkg::FLAG_100MS];
    result.flag_10ms       = flags_nxt[ttb_pkg::FLAG_10MS];
    result.scroll_upper    = flags_nxt[ttb_pkg::FLAG_SCR_UP];
    result.scroll_lower    = flags_nxt[ttb_pkg::FLAG_SCR_LO];
    result.interval_passed = {{(ttb_pkg::LIMIT_W-16){1'b0}}, interval_nxt}
                             >= item.limit_tenths;
    result.phase_passed    = {{(ttb_pkg::LIMIT_W-16){1'b0}}, phase_nxt}
                             >= item.limit_tenths;
    result.blink_on        = blink_nxt < ttb_pkg::BLINK_ON_BELOW;
    result.hours           = hours_nxt;
    result.minutes         = minutes_nxt;
    result.seconds         = seconds_nxt;
    result.tenths          = tenths_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= 4'd0;
      interval_r <= 16'd0;
      phase_r    <= 16'd0;
      blink_r    <= 4'd0;
      scroll_r   <= 2'd0;
      flags_r    <= 4'd0;
      tenths_r   <= 4'd0;
      seconds_r  <= 6'd0;
      minutes_r  <= 6'd0;
      hours_r    <= 5'd0;
    end else begin
      prescale_r <= prescale_nxt;
      interval_r <= interval_nxt;
      phase_r    <= phase_nxt;
      blink_r    <= blink_nxt;
      scroll_r   <= scroll_nxt;
      flags_r    <= flags_nxt;
      tenths_r   <= tenths_nxt;
      seconds_r  <= seconds_nxt;
      minutes_r  <= minutes_nxt;
      hours_r    <= hours_nxt;
    end
  end

endmodule

// ===== hw/rtl/ttb_out_stage.sv =====
module ttb_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  ttb_pkg::out_word_t result,
  ttb_if.source              out_ch,
  output logic               out_free
);

  logic               valid_r;
  ttb_pkg::out_word_t data_r;

  assign out_ch.valid = valid_r;
  assign out_ch.data  = data_r;
  assign out_free     = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // hold the word until taken
  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= result;
    end
  end

endmodule

// ===== hw/rtl/tick_timebase_with_clock.sv =====
// 10 ms tick prescaler with 100 ms timers and a time-of-day clock.
// in_ch carries one word per event: mode 0 is a 10 ms tick, mode 1 a poll
// that clears the pending flags selected by ack_mask. Either word may clear
// the interval and phase timers and compares both with limit_seconds * 10.
// out_ch returns exactly one result word per input word, in order: the
// pending flags, both compare results, blink state and the clock fields.
// cfg_ch writes the start hours, minutes and seconds (index 0, 1, 2); each
// write loads the clock field at once. Write only while no word is in flight.
// From input accept to output valid, the input stage registers the word and
// scales the limit; once the output register is free, the core updates its
// state and the output register loads the result on the same edge.
// Throughput is one word per cycle while the receiver does not stall.
// When the receiver stalls, the output word holds and the input stage keeps
// one more word, so in_ch.ready drops only with both stages full.
// Synchronous reset clears all counters, flags and the clock to zero and
// empties both stages; cfg_ch is always ready.
`include "assert_macros.svh"

module tick_timebase_with_clock #(
  parameter int TENTHS_PER_SECOND = 10
) (
  input logic   clk,
  input logic   rst_n,
  ttb_if.sink   in_ch,
  ttb_if.source out_ch,
  ttb_if.sink   cfg_ch
);

  logic               item_valid;
  ttb_pkg::item_t     item;
  logic               out_free;
  logic               advance;
  ttb_pkg::out_word_t result;
  ttb_pkg::cfg_wr_t   cfg;

  assign advance      = item_valid && out_free;
  assign cfg_ch.ready = 1'b1;
  assign cfg.en       = cfg_ch.valid && cfg_ch.ready;
  assign cfg.word     = cfg_ch.data;

  ttb_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ttb_core #(
    .TENTHS_PER_SECOND (TENTHS_PER_SECOND)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  ttb_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .result   (result),
    .out_ch   (out_ch),
    .out_free (out_free)
  );

  `ASSERT_NEXT(a_advance_shows, clk, rst_n, advance, out_ch.valid)
  `ASSERT_SAME(a_stall_blocks, clk, rst_n, out_ch.valid && !out_ch.ready, !advance)
  `ASSERT_NEXT(a_accept_holds, clk, rst_n, in_ch.valid && in_ch.ready, item_valid)

endmodule
